### hdl/efws_pkg.sv
// Shared types and constants for the earliest-free-worker scheduler.
// Field widths, register codes and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package efws_pkg;

    // Field widths
    localparam int TIME_W = 48;
    localparam int DUR_W  = 32;
    localparam int ID_W   = 8;
    localparam int CNT_W  = 9;

    // Register port widths
    localparam int APB_DW = 32;
    localparam int APB_AW = 3;

    // Register index (paddr[2])
    localparam logic REG_WORKER_COUNT = 1'b0;

    // Reset value of the worker count
    localparam logic [CNT_W-1:0] COUNT_RESET = 9'd1;

    typedef logic [TIME_W-1:0] t_time;

    // Sequencer states, one-hot
    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_SCAN  = 6'b000100,
        ST_DRAIN = 6'b001000,
        ST_LEAF  = 6'b010000,
        ST_CLIMB = 6'b100000
    } t_state;

endpackage

`default_nettype wire

### hdl/efws_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Used for the min-tree node store. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module efws_ram #(
    parameter int WIDTH = 56,
    parameter int DEPTH = 512,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### hdl/efws_apb.sv
// APB-style register block holding the worker count.
// Depends on efws_pkg.
`timescale 1ns / 1ps
`default_nettype none

module efws_apb (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [efws_pkg::APB_AW-1:0] paddr,
    input  wire logic [efws_pkg::APB_DW-1:0] pwdata,
    output logic      [efws_pkg::APB_DW-1:0] prdata,
    output logic                             pready,
    output logic      [efws_pkg::CNT_W-1:0]  o_worker_count
);

    import efws_pkg::*;

    logic             w_wr;
    logic [CNT_W-1:0] r_count;

    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;

    // Write the worker count in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= COUNT_RESET;
        end else if (w_wr && (paddr[2] == REG_WORKER_COUNT)) begin
            r_count <= pwdata[CNT_W-1:0];
        end
    end

    // Read back
    always_comb begin
        if (paddr[2] == REG_WORKER_COUNT) begin
            prdata = APB_DW'(r_count);
        end else begin
            prdata = '0;
        end
    end

    assign o_worker_count = r_count;

endmodule

`default_nettype wire

### hdl/efws_engine.sv
// Sequencer for the min-tree scheduler: clear pass, prefix-min query,
// leaf update with saturation and bottom-up rebuild. Depends on efws_pkg.
`timescale 1ns / 1ps
`default_nettype none

module efws_engine #(
    parameter int  MAX_WORKERS = 256,
    localparam int LVL    = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 0,
    localparam int LEAVES = 1 << LVL,
    localparam int AW     = LVL + 1,
    localparam int IDX_W  = (LVL > 0) ? LVL : 1,
    localparam int NODE_W = efws_pkg::TIME_W + IDX_W,
    localparam int BW     = (LVL > 0) ? $clog2(LVL + 1) : 1
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [efws_pkg::CNT_W-1:0] i_worker_count,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic [efws_pkg::DUR_W-1:0] i_duration,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic      [efws_pkg::ID_W-1:0]  o_worker_id,
    output efws_pkg::t_time                 o_start_time,
    output logic                            o_we,
    output logic      [AW-1:0]              o_waddr,
    output logic      [NODE_W-1:0]          o_wdata,
    output logic      [AW-1:0]              o_raddr,
    input  wire logic [NODE_W-1:0]          i_rdata
);

    import efws_pkg::*;

    t_state             r_state, n_state;
    logic [AW-1:0]      r_cnt, n_cnt;
    logic [AW-1:0]      r_pre, n_pre;
    logic [AW-1:0]      r_node, n_node;
    logic [AW-1:0]      r_clr_k, n_clr_k;
    logic [AW-1:0]      r_clr_leaf, n_clr_leaf;
    logic [AW-1:0]      r_clr_step, n_clr_step;
    logic [BW-1:0]      r_bit, n_bit;
    logic               r_rd_vld, n_rd_vld;
    logic               r_have, n_have;
    t_time              r_best_val, n_best_val;
    logic [IDX_W-1:0]   r_best_idx, n_best_idx;
    t_time              r_cur_val, n_cur_val;
    logic [IDX_W-1:0]   r_cur_idx, n_cur_idx;
    logic [DUR_W-1:0]   r_dur, n_dur;
    logic               r_o_valid, n_o_valid;
    logic [ID_W-1:0]    r_o_id, n_o_id;
    t_time              r_o_start, n_o_start;

    logic [AW-1:0]      w_eff;
    t_time              w_rd_val;
    logic [IDX_W-1:0]   w_rd_idx;
    logic [AW-1:0]      w_scan_node;
    logic               w_bit_set;
    logic               w_better;
    logic [TIME_W:0]    w_sum;
    t_time              w_new;
    logic [AW-1:0]      w_leaf;
    logic [AW-1:0]      w_parent;
    t_time              w_l_val, w_r_val, w_par_val;
    logic [IDX_W-1:0]   w_l_idx, w_r_idx, w_par_idx;
    logic               w_out_free;

    // Clamp the configured count to 1..MAX_WORKERS
    always_comb begin
        if (i_worker_count == '0) begin
            w_eff = AW'(1);
        end else if (32'(i_worker_count) > 32'(MAX_WORKERS)) begin
            w_eff = AW'(MAX_WORKERS);
        end else begin
            w_eff = AW'(i_worker_count);
        end
    end

    assign w_rd_val = i_rdata[NODE_W-1 -: TIME_W];
    assign w_rd_idx = i_rdata[IDX_W-1:0];

    // Node covering the next power-of-two block of the prefix
    assign w_scan_node = AW'((AW'(LEAVES) + r_pre) >> r_bit);
    assign w_bit_set   = r_cnt[r_bit];

    // Later candidates lie further right: take them only when strictly earlier
    assign w_better = r_rd_vld && (!r_have || (w_rd_val < r_best_val));

    // Saturating finish-time update
    assign w_sum = {1'b0, r_best_val} + (TIME_W + 1)'(r_dur);
    assign w_new = w_sum[TIME_W] ? '1 : w_sum[TIME_W-1:0];

    assign w_leaf   = AW'(LEAVES) + AW'(r_best_idx);
    assign w_parent = r_node >> 1;

    // Merge current node with its sibling; ties go to the left child
    always_comb begin
        if (!r_node[0]) begin
            w_l_val = r_cur_val;
            w_l_idx = r_cur_idx;
            w_r_val = w_rd_val;
            w_r_idx = w_rd_idx;
        end else begin
            w_l_val = w_rd_val;
            w_l_idx = w_rd_idx;
            w_r_val = r_cur_val;
            w_r_idx = r_cur_idx;
        end
        if (w_l_val <= w_r_val) begin
            w_par_val = w_l_val;
            w_par_idx = w_l_idx;
        end else begin
            w_par_val = w_r_val;
            w_par_idx = w_r_idx;
        end
    end

    assign w_out_free = !r_o_valid || i_out_ready;

    // Next-state and memory access logic
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_pre      = r_pre;
        n_node     = r_node;
        n_clr_k    = r_clr_k;
        n_clr_leaf = r_clr_leaf;
        n_clr_step = r_clr_step;
        n_bit      = r_bit;
        n_rd_vld   = r_rd_vld;
        n_have     = r_have;
        n_best_val = r_best_val;
        n_best_idx = r_best_idx;
        n_cur_val  = r_cur_val;
        n_cur_idx  = r_cur_idx;
        n_dur      = r_dur;
        n_o_valid  = r_o_valid;
        n_o_id     = r_o_id;
        n_o_start  = r_o_start;
        o_we       = 1'b0;
        o_waddr    = r_clr_k;
        o_wdata    = {t_time'(0), r_clr_leaf[IDX_W-1:0]};
        o_raddr    = w_scan_node;

        // Drop the result once taken
        if (r_o_valid && i_out_ready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            ST_CLEAR: begin
                // Write each node as zero, owned by its leftmost leaf
                o_we    = 1'b1;
                n_clr_k = r_clr_k + AW'(1);
                if ((r_clr_leaf + r_clr_step) == AW'(LEAVES)) begin
                    n_clr_leaf = '0;
                    n_clr_step = r_clr_step >> 1;
                end else begin
                    n_clr_leaf = r_clr_leaf + r_clr_step;
                end
                if (r_clr_k == AW'(2 * LEAVES - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_cnt    = w_eff;
                    n_dur    = i_duration;
                    n_bit    = BW'(LVL);
                    n_pre    = '0;
                    n_have   = 1'b0;
                    n_rd_vld = 1'b0;
                    n_state  = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // Fold in the previous read, issue the next block read
                if (w_better) begin
                    n_best_val = w_rd_val;
                    n_best_idx = w_rd_idx;
                end
                if (r_rd_vld) begin
                    n_have = 1'b1;
                end
                n_rd_vld = w_bit_set;
                if (w_bit_set) begin
                    n_pre = r_pre + (AW'(1) << r_bit);
                end
                if (r_bit == '0) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_bit = r_bit - BW'(1);
                end
            end
            ST_DRAIN: begin
                if (w_better) begin
                    n_best_val = w_rd_val;
                    n_best_idx = w_rd_idx;
                end
                n_have   = 1'b1;
                n_rd_vld = 1'b0;
                n_state  = ST_LEAF;
            end
            ST_LEAF: begin
                // Update the chosen leaf and post the item once the output is free; fetch the sibling
                o_raddr = w_leaf ^ AW'(1);
                if (w_out_free) begin
                    o_we      = 1'b1;
                    o_waddr   = w_leaf;
                    o_wdata   = {w_new, r_best_idx};
                    n_o_valid = 1'b1;
                    n_o_id    = ID_W'(r_best_idx);
                    n_o_start = r_best_val;
                    n_node    = w_leaf;
                    n_cur_val = w_new;
                    n_cur_idx = r_best_idx;
                    n_state   = (LVL == 0) ? ST_IDLE : ST_CLIMB;
                end
            end
            ST_CLIMB: begin
                // Rebuild one ancestor per cycle up to the root
                o_we      = 1'b1;
                o_waddr   = w_parent;
                o_wdata   = {w_par_val, w_par_idx};
                o_raddr   = w_parent ^ AW'(1);
                n_node    = w_parent;
                n_cur_val = w_par_val;
                n_cur_idx = w_par_idx;
                if (w_parent == AW'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_k    <= AW'(1);
            r_clr_leaf <= '0;
            r_clr_step <= AW'(LEAVES);
            r_rd_vld   <= 1'b0;
            r_have     <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_k    <= n_clr_k;
            r_clr_leaf <= n_clr_leaf;
            r_clr_step <= n_clr_step;
            r_rd_vld   <= n_rd_vld;
            r_have     <= n_have;
            r_o_valid  <= n_o_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cnt      <= n_cnt;
        r_pre      <= n_pre;
        r_node     <= n_node;
        r_bit      <= n_bit;
        r_best_val <= n_best_val;
        r_best_idx <= n_best_idx;
        r_cur_val  <= n_cur_val;
        r_cur_idx  <= n_cur_idx;
        r_dur      <= n_dur;
        r_o_id     <= n_o_id;
        r_o_start  <= n_o_start;
    end

    assign o_in_ready   = (r_state == ST_IDLE);
    assign o_out_valid  = r_o_valid;
    assign o_worker_id  = r_o_id;
    assign o_start_time = r_o_start;

endmodule

`default_nettype wire

### hdl/earliest_free_worker_scheduler.sv
// An item goes through the query (ST_SCAN, ST_DRAIN), the leaf update (ST_LEAF),
// which posts the result once the output is free, and the rebuild (ST_CLIMB). A new item
// is taken only in ST_IDLE, after the rebuild, as the min-tree RAM gives one read per
// cycle: the query reads blocks of the prefix, the rebuild one sibling per level. Reset:
// synchronous; then a clearing pass writes every tree node while no item is accepted.
// Top level: register block, sequencer and min-tree RAM. Depends on efws_pkg.
`timescale 1ns / 1ps
`default_nettype none

module earliest_free_worker_scheduler #(
    parameter int MAX_WORKERS = 256
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [efws_pkg::APB_AW-1:0] paddr,
    input  wire logic [efws_pkg::APB_DW-1:0] pwdata,
    output logic      [efws_pkg::APB_DW-1:0] prdata,
    output logic                             pready,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [efws_pkg::DUR_W-1:0]  i_duration,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic      [efws_pkg::ID_W-1:0]   o_worker_id,
    output efws_pkg::t_time                  o_start_time
);

    import efws_pkg::*;

    localparam int LVL    = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 0;
    localparam int LEAVES = 1 << LVL;
    localparam int AW     = LVL + 1;
    localparam int IDX_W  = (LVL > 0) ? LVL : 1;
    localparam int NODE_W = TIME_W + IDX_W;

    logic [CNT_W-1:0]  w_worker_count;
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [NODE_W-1:0] w_wdata;
    logic [AW-1:0]     w_raddr;
    logic [NODE_W-1:0] w_rdata;

    efws_apb u_apb (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_worker_count (w_worker_count)
    );

    efws_engine #(
        .MAX_WORKERS (MAX_WORKERS)
    ) u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_worker_count (w_worker_count),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_duration     (i_duration),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_worker_id    (o_worker_id),
        .o_start_time   (o_start_time),
        .o_we           (w_we),
        .o_waddr        (w_waddr),
        .o_wdata        (w_wdata),
        .o_raddr        (w_raddr),
        .i_rdata        (w_rdata)
    );

    // Node store: node 1 is the root, leaves sit at LEAVES + worker
    efws_ram #(
        .WIDTH (NODE_W),
        .DEPTH (2 * LEAVES)
    ) u_tree_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

endmodule

`default_nettype wire

### hdl/efws_chk.sv
// Port-level checker for the scheduler, bound to the top level.
// Depends only on the top-level ports.
`timescale 1ns / 1ps
`default_nettype none

module efws_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [7:0]  o_worker_id,
    input wire logic [47:0] o_start_time
);

    // Clearing pass follows reset: nothing accepted, nothing posted
    a_reset_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> (!o_in_ready && !o_out_valid))
        else $error("input ready or result valid right after reset");

    // One item at a time: busy after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready in the cycle after an accept");

    // A result never appears the cycle after its item is taken
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !$rose(o_out_valid))
        else $error("result posted one cycle after accept");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_worker_id) && $stable(o_start_time)))
        else $error("stalled result changed or dropped");

endmodule

bind earliest_free_worker_scheduler efws_chk u_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_worker_id  (o_worker_id),
    .o_start_time (o_start_time)
);

`default_nettype wire
